// File: rtl/lagged_base_pair_counter_defines.svh
// assertion macros for the lagged base pair counter
// no dependencies; included by the rtl files that carry assertions
`ifndef LAGGED_BASE_PAIR_COUNTER_DEFINES_SVH
`define LAGGED_BASE_PAIR_COUNTER_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define LBPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define LBPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lbpc_pkg.sv
// shared types and constants of the lagged base pair counter
// no dependencies; used by the channel interfaces and the top level
package lbpc_pkg;

    localparam int C_OP_W   = 2;
    localparam int C_CHAR_W = 8;
    localparam int C_LAG_W  = 5;
    localparam int C_BASE_W = 2;
    localparam int C_OUT_W  = 32;

    localparam logic [C_LAG_W-1:0] C_LAG_RESET = 5'd30;

    // ascii codes of the counted letters
    localparam logic [C_CHAR_W-1:0] C_CHR_A = 8'h41;
    localparam logic [C_CHAR_W-1:0] C_CHR_T = 8'h54;
    localparam logic [C_CHAR_W-1:0] C_CHR_G = 8'h47;
    localparam logic [C_CHAR_W-1:0] C_CHR_C = 8'h43;

    // base codes
    localparam logic [C_BASE_W-1:0] C_BASE_A = 2'd0;
    localparam logic [C_BASE_W-1:0] C_BASE_T = 2'd1;
    localparam logic [C_BASE_W-1:0] C_BASE_G = 2'd2;
    localparam logic [C_BASE_W-1:0] C_BASE_C = 2'd3;

    typedef enum logic [C_OP_W-1:0] {
        OP_FEED    = 2'd0,
        OP_RD_PAIR = 2'd1,
        OP_RD_BASE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PAIR   = 7'b0000010,
        S_FLUSH  = 7'b0000100,
        S_RDREQ  = 7'b0001000,
        S_RDDATA = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

endpackage

// File: rtl/lbpc_if.sv
// valid/ready channel interfaces: input beats, result beats, config writes
// depends on lbpc_pkg
interface lbpc_in_if import lbpc_pkg::*; ();
    logic                valid;
    logic                ready;
    t_op                 op;
    logic [C_CHAR_W-1:0] char_byte;
    logic [C_LAG_W-1:0]  lag_index;
    logic [C_BASE_W-1:0] first_base;
    logic [C_BASE_W-1:0] second_base;

    modport source (output valid, op, char_byte, lag_index, first_base, second_base,
                    input ready);
    modport sink   (input valid, op, char_byte, lag_index, first_base, second_base,
                    output ready);
endinterface

interface lbpc_out_if import lbpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [C_OUT_W-1:0] count_value;

    modport source (output valid, accepted, count_value, input ready);
    modport sink   (input valid, accepted, count_value, output ready);
endinterface

interface lbpc_cfg_if import lbpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [C_LAG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/lagged_base_pair_counter.sv
// lagged base pair counter top level: pair count memory, window, base counts
// depends on lbpc_pkg, lbpc_if.sv and lagged_base_pair_counter_defines.svh
`include "lagged_base_pair_counter_defines.svh"

// Counts A/T/G/C bases of a byte stream and, for each base, the pairs it forms
// with the up to lag_count earlier bases in its window, by distance. Every input
// beat gives exactly one result beat. After an accepted beat the block stays busy
// while it works: a fed base with n > 0 earlier bases to pair walks its n pairs
// (n = min(bases seen since clear, lag_count, MAX_LAG)), since the pair counters
// sit in one single-port-per-side memory updated by one read-modify-write a
// cycle; a pair read makes one memory read; a base read, an ignored byte or
// a fed base with nothing to pair goes straight to its result; clear zeroes
// the memory, one row per cycle. After reset a clearing pass over all MAX_LAG*16
// rows runs before the first input beat is taken; config writes are taken at any
// time. Results are held in an output register, so a new input beat is taken
// while a result beat still waits.
module lagged_base_pair_counter import lbpc_pkg::*; #(
    parameter int MAX_LAG     = 30,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbpc_cfg_if.sink    i_cfg,
    lbpc_in_if.sink     i_in,
    lbpc_out_if.source  o_out
);

    localparam int DEPTH = MAX_LAG * 16;
    localparam int LW    = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int AW    = LW + 2 * C_BASE_W;
    localparam int FW    = $clog2(MAX_LAG + 1);

    // control state
    t_state              r_state;
    t_state              n_state;
    logic [C_LAG_W-1:0]  r_lag;
    logic [FW-1:0]       r_fill;
    logic [C_BASE_W-1:0] r_win [MAX_LAG];
    logic [COUNT_WIDTH-1:0] r_bcnt [4];
    logic [LW-1:0]       r_d;
    logic                r_wr_pend;
    logic [AW-1:0]       r_clr_addr;
    logic                r_clr_reply;
    logic                r_out_valid;

    // payload
    logic [C_BASE_W-1:0] r_cur;
    logic [FW-1:0]       r_n;
    logic [AW-1:0]       r_rd_addr;
    logic [AW-1:0]       r_wr_addr;
    logic                r_res_acc;
    logic [C_OUT_W-1:0]  r_res_val;
    logic                r_out_acc;
    logic [C_OUT_W-1:0]  r_out_val;

    // pair count memory
    logic [COUNT_WIDTH-1:0] r_pair_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rdata;

    logic                   in_fire;
    logic                   chr_ok;
    logic [C_BASE_W-1:0]    chr_code;
    logic [FW-1:0]          eff_lag;
    logic [FW-1:0]          n_pairs;
    logic [C_BASE_W-1:0]    win_base;
    logic [AW-1:0]          pair_addr;
    logic                   pair_last;
    logic                   clr_last;
    logic                   out_free;
    logic                   win_shift;
    logic [C_BASE_W-1:0]    shift_code;
    logic                   mem_re;
    logic [AW-1:0]          mem_ra;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;
    logic [COUNT_WIDTH-1:0] rmw_inc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_out_acc;
    assign o_out.count_value = r_out_val;
    assign out_free          = !r_out_valid || o_out.ready;

    // letter decode
    always_comb begin
        chr_ok   = 1'b1;
        chr_code = C_BASE_A;
        unique case (i_in.char_byte)
            C_CHR_A: chr_code = C_BASE_A;
            C_CHR_T: chr_code = C_BASE_T;
            C_CHR_G: chr_code = C_BASE_G;
            C_CHR_C: chr_code = C_BASE_C;
            default: chr_ok   = 1'b0;
        endcase
    end

    // number of earlier bases this base pairs with
    assign eff_lag = (32'(r_lag) > MAX_LAG) ? FW'(MAX_LAG) : FW'(r_lag);
    assign n_pairs = (r_fill < eff_lag) ? r_fill : eff_lag;

    // pair walk: distance r_d, earlier base from the window, current base
    assign win_base  = r_win[r_d];
    assign pair_addr = {r_d, win_base, r_cur};
    assign pair_last = (32'(r_d) + 1) == 32'(r_n);
    assign clr_last  = (r_clr_addr == AW'(DEPTH - 1));

    // window shifts once per counted base, after its pairs have been read
    assign win_shift  = (in_fire && i_in.op == OP_FEED && chr_ok && n_pairs == '0) ||
                        (r_state == S_PAIR && pair_last);
    assign shift_code = (r_state == S_PAIR) ? r_cur : chr_code;

    // memory ports: reads for the walk and for pair reads, write-back in the cycle after the read
    assign rmw_inc = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
    assign mem_re  = (r_state == S_PAIR) || (r_state == S_RDREQ);
    assign mem_ra  = (r_state == S_PAIR) ? pair_addr : r_rd_addr;
    assign mem_we  = r_wr_pend || (r_state == S_CLEAR);
    assign mem_wa  = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
    assign mem_wd  = (r_state == S_CLEAR) ? '0 : rmw_inc;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pair_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_pair_mem[mem_ra];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.op)
                        OP_FEED:    n_state = (chr_ok && n_pairs != '0) ? S_PAIR : S_DONE;
                        OP_RD_PAIR: n_state = (32'(i_in.lag_index) < MAX_LAG) ? S_RDREQ
                                                                              : S_DONE;
                        OP_RD_BASE: n_state = S_DONE;
                        OP_CLEAR:   n_state = S_CLEAR;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_PAIR:   n_state = pair_last ? S_FLUSH : S_PAIR;
            S_FLUSH:  n_state = S_DONE;
            S_RDREQ:  n_state = S_RDDATA;
            S_RDDATA: n_state = S_DONE;
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_DONE:   n_state = out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_lag       <= C_LAG_RESET;
            r_fill      <= '0;
            r_d         <= '0;
            r_wr_pend   <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_LAG; i++) begin
                r_win[i] <= '0;
            end
            for (int b = 0; b < 4; b++) begin
                r_bcnt[b] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_wr_pend <= (r_state == S_PAIR);

            if (i_cfg.valid && i_cfg.ready) begin
                r_lag <= i_cfg.data;
            end

            if (in_fire) begin
                r_d <= '0;
                if (i_in.op == OP_FEED && chr_ok) begin
                    if (r_bcnt[chr_code] != '1) begin
                        r_bcnt[chr_code] <= r_bcnt[chr_code] + 1'b1;
                    end
                    if (32'(r_fill) < MAX_LAG) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                if (i_in.op == OP_CLEAR) begin
                    r_fill      <= '0;
                    r_clr_addr  <= '0;
                    r_clr_reply <= 1'b1;
                    for (int b = 0; b < 4; b++) begin
                        r_bcnt[b] <= '0;
                    end
                end
            end else if (r_state == S_PAIR) begin
                r_d <= r_d + 1'b1;
            end

            // clear leaves the window zeroed, as after reset
            if (in_fire && i_in.op == OP_CLEAR) begin
                for (int i = 0; i < MAX_LAG; i++) begin
                    r_win[i] <= '0;
                end
            end else if (win_shift) begin
                r_win[0] <= shift_code;
                for (int i = 1; i < MAX_LAG; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            // output register: load a finished result, drop it once taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cur     <= chr_code;
            r_n       <= n_pairs;
            r_rd_addr <= {LW'(i_in.lag_index), i_in.first_base, i_in.second_base};
            r_res_acc <= (i_in.op == OP_FEED) && chr_ok;
            r_res_val <= (i_in.op == OP_RD_BASE) ? C_OUT_W'(r_bcnt[i_in.first_base]) : '0;
        end
        if (r_state == S_RDDATA) begin
            r_res_val <= C_OUT_W'(r_rdata);
        end
        r_wr_addr <= pair_addr;
        if (r_state == S_DONE && out_free) begin
            r_out_acc <= r_res_acc;
            r_out_val <= r_res_val;
        end
    end

    `LBPC_ASSERT_IMP(a_no_rw_same_entry, i_clk, i_rst_n, mem_we && mem_re,
        mem_wa != mem_ra, "read and write-back hit the same pair entry")
    `LBPC_ASSERT_NXT(a_walk_writes_back, i_clk, i_rst_n, r_state == S_PAIR,
        r_wr_pend, "pair read not followed by write-back")
    `LBPC_ASSERT_IMP(a_clear_no_rmw, i_clk, i_rst_n, r_state == S_CLEAR,
        !r_wr_pend, "clear sweep overlaps a pending write-back")
    `LBPC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, r_state != S_CLEAR,
        32'(r_fill) <= MAX_LAG, "window fill beyond window size")

endmodule
